// File: sv/modbus_tcp_request_framer_assert.svh
// assertion macros shared by the request framer modules
`ifndef MODBUS_TCP_REQUEST_FRAMER_ASSERT_SVH
`define MODBUS_TCP_REQUEST_FRAMER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define MTRF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication whose consequent must hold in the cycle after the antecedent
`define MTRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mtrf_pkg.sv
// types and constants of the modbus tcp request framer
`default_nettype none

package mtrf_pkg;

    localparam logic [7:0]  FC_WRITE_COIL   = 8'h05;
    localparam logic [7:0]  FC_WRITE_REG    = 8'h06;
    localparam logic [7:0]  FC_WRITE_COILS  = 8'h0F;
    localparam logic [7:0]  FC_WRITE_REGS   = 8'h10;

    localparam logic [7:0]  UNIT_ID         = 8'hFF;
    localparam logic [15:0] COIL_LIMIT      = 16'd1968;
    localparam logic [15:0] REG_LIMIT       = 16'd123;
    localparam logic [15:0] COIL_ON         = 16'hFF00;
    localparam logic [7:0]  BASE_LEN        = 8'd6;
    localparam logic [7:0]  MULTI_LEN       = 8'd7;

    // byte positions inside a frame
    localparam int          IDX_W           = 4;
    localparam logic [3:0]  BP_TID_HI       = 4'd0;
    localparam logic [3:0]  BP_TID_LO       = 4'd1;
    localparam logic [3:0]  BP_PROTO_HI     = 4'd2;
    localparam logic [3:0]  BP_PROTO_LO     = 4'd3;
    localparam logic [3:0]  BP_LEN_HI       = 4'd4;
    localparam logic [3:0]  BP_LEN_LO       = 4'd5;
    localparam logic [3:0]  BP_UNIT         = 4'd6;
    localparam logic [3:0]  BP_FUNC         = 4'd7;
    localparam logic [3:0]  BP_ADDR_HI      = 4'd8;
    localparam logic [3:0]  BP_ADDR_LO      = 4'd9;
    localparam logic [3:0]  BP_TAIL_HI      = 4'd10;
    localparam logic [3:0]  BP_TAIL_LO      = 4'd11;
    localparam logic [3:0]  BP_BCOUNT       = 4'd12;
    localparam logic [3:0]  BP_DATA_FIRST   = 4'd13;
    localparam logic [3:0]  BP_DATA_SECOND  = 4'd14;

    localparam int          QDEPTH          = 2;
    localparam int          QPTR_W          = $clog2(QDEPTH);
    localparam int          QCNT_W          = $clog2(QDEPTH + 1);

    // one job for the byte serializer: a span of frame byte positions
    typedef struct packed {
        logic                err;
        logic                ends;
        logic [IDX_W-1:0]    start_idx;
        logic [IDX_W-1:0]    end_idx;
        logic [15:0]         tid;
        logic [7:0]          len;
        logic [7:0]          func;
        logic [15:0]         addr;
        logic [15:0]         tail;
        logic [7:0]          bcount;
        logic [7:0]          data_first;
        logic [7:0]          data_second;
    } desc_t;

endpackage

`default_nettype wire

// File: sv/mtrf_queue.sv
// short job queue between the classifier and the byte serializer
`default_nettype none

`include "modbus_tcp_request_framer_assert.svh"

module mtrf_queue import mtrf_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire desc_t push_desc,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output desc_t      head_desc
);

    desc_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    `MTRF_ASSERT(a_q_no_overflow, !(push && full && !pop), "push into a full job queue")
    `MTRF_ASSERT(a_q_no_underflow, !(pop && !head_valid), "pop from an empty job queue")

endmodule

`default_nettype wire

// File: sv/mtrf_front.sv
// accepts request words, classifies them and builds serializer jobs
`default_nettype none

module mtrf_front import mtrf_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_func,
    input  wire logic [15:0]  s_start_addr,
    input  wire logic [15:0]  s_count,
    input  wire logic [15:0]  s_value,
    output logic              q_push,
    output desc_t             q_desc,
    input  wire logic         q_full
);

    logic [15:0] tid_reg, tid_next;
    logic [6:0]  words_rem_reg, words_rem_next;
    logic        coil_mode_reg, coil_mode_next;
    logic        odd_reg, odd_next;

    logic        accept;
    logic        cont;
    logic        is_coils;
    logic        is_regs;
    logic        multi;
    logic        over;
    logic [16:0] coil_bytes_sum;
    logic [7:0]  coil_bytes;
    logic [8:0]  coil_words_sum;
    logic [6:0]  words;
    logic [7:0]  bytes;
    logic        odd_new;
    logic        order_coil;
    logic        last_word;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    assign cont     = (words_rem_reg != '0);
    assign is_coils = (s_func == FC_WRITE_COILS);
    assign is_regs  = (s_func == FC_WRITE_REGS);
    assign multi    = is_coils || is_regs;
    assign over     = (is_coils && (s_count > COIL_LIMIT)) || (is_regs && (s_count > REG_LIMIT));

    // coil byte count is ceil(count/8), word count ceil(bytes/2)
    assign coil_bytes_sum = {1'b0, s_count} + 17'd7;
    assign coil_bytes     = coil_bytes_sum[10:3];
    assign coil_words_sum = {1'b0, coil_bytes} + 9'd1;
    assign bytes          = is_coils ? coil_bytes : {s_count[6:0], 1'b0};
    assign words          = is_coils ? coil_words_sum[7:1] : s_count[6:0];
    assign odd_new        = is_coils && bytes[0];

    // coil words go low byte first
    assign order_coil = cont ? coil_mode_reg : is_coils;

    always_comb begin
        q_desc             = '0;
        q_desc.tid         = tid_reg;
        q_desc.func        = s_func;
        q_desc.addr        = s_start_addr;
        q_desc.bcount      = bytes;
        q_desc.len         = BASE_LEN;
        q_desc.data_first  = order_coil ? s_value[7:0] : s_value[15:8];
        q_desc.data_second = order_coil ? s_value[15:8] : s_value[7:0];
        q_desc.start_idx   = BP_TID_HI;
        last_word          = 1'b0;
        if (cont) begin
            last_word        = (words_rem_reg == 7'd1);
            q_desc.start_idx = BP_DATA_FIRST;
            q_desc.end_idx   = (last_word && odd_reg) ? BP_DATA_FIRST : BP_DATA_SECOND;
            q_desc.ends      = last_word;
        end else if (over) begin
            q_desc.err     = 1'b1;
            q_desc.end_idx = BP_TID_HI;
        end else if (multi) begin
            q_desc.tail = s_count;
            q_desc.len  = MULTI_LEN + bytes;
            if (words == '0) begin
                q_desc.end_idx = BP_BCOUNT;
                q_desc.ends    = 1'b1;
            end else begin
                last_word      = (words == 7'd1);
                q_desc.end_idx = (last_word && odd_new) ? BP_DATA_FIRST : BP_DATA_SECOND;
                q_desc.ends    = last_word;
            end
        end else begin
            q_desc.end_idx = BP_TAIL_LO;
            q_desc.ends    = 1'b1;
            case (s_func)
                FC_WRITE_COIL: q_desc.tail = (s_value != '0) ? COIL_ON : '0;
                FC_WRITE_REG:  q_desc.tail = s_value;
                default:       q_desc.tail = s_count;
            endcase
        end
    end

    always_comb begin
        tid_next       = tid_reg;
        words_rem_next = words_rem_reg;
        coil_mode_next = coil_mode_reg;
        odd_next       = odd_reg;
        if (accept) begin
            if (cont) begin
                words_rem_next = words_rem_reg - 7'd1;
            end else if (!over) begin
                tid_next = tid_reg + 16'd1;
                if (multi) begin
                    coil_mode_next = is_coils;
                    odd_next       = odd_new;
                    words_rem_next = (words == '0) ? '0 : words - 7'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tid_reg       <= '0;
            words_rem_reg <= '0;
            coil_mode_reg <= 1'b0;
            odd_reg       <= 1'b0;
        end else begin
            tid_reg       <= tid_next;
            words_rem_reg <= words_rem_next;
            coil_mode_reg <= coil_mode_next;
            odd_reg       <= odd_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/mtrf_back.sv
// walks each job's byte positions and drives the output byte register
`default_nettype none

`include "modbus_tcp_request_framer_assert.svh"

module mtrf_back import mtrf_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         head_valid,
    input  wire desc_t        head_desc,
    output logic              pop,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [7:0]        m_frame_byte,
    output logic              m_frame_last,
    output logic              m_error
);

    logic             active_reg, active_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             error_reg;

    logic [IDX_W-1:0] cur_idx;
    logic             at_end;
    logic             load;
    logic [7:0]       sel_byte;

    // mid-job the counter runs, otherwise start at the job's first position
    assign cur_idx = active_reg ? idx_reg : head_desc.start_idx;
    assign at_end  = (cur_idx == head_desc.end_idx);
    assign load    = head_valid && (!m_valid_reg || m_ready);
    assign pop     = load && at_end;

    always_comb begin
        case (cur_idx)
            BP_TID_HI:      sel_byte = head_desc.tid[15:8];
            BP_TID_LO:      sel_byte = head_desc.tid[7:0];
            BP_PROTO_HI:    sel_byte = 8'h00;
            BP_PROTO_LO:    sel_byte = 8'h00;
            BP_LEN_HI:      sel_byte = 8'h00;
            BP_LEN_LO:      sel_byte = head_desc.len;
            BP_UNIT:        sel_byte = UNIT_ID;
            BP_FUNC:        sel_byte = head_desc.func;
            BP_ADDR_HI:     sel_byte = head_desc.addr[15:8];
            BP_ADDR_LO:     sel_byte = head_desc.addr[7:0];
            BP_TAIL_HI:     sel_byte = head_desc.tail[15:8];
            BP_TAIL_LO:     sel_byte = head_desc.tail[7:0];
            BP_BCOUNT:      sel_byte = head_desc.bcount;
            BP_DATA_FIRST:  sel_byte = head_desc.data_first;
            BP_DATA_SECOND: sel_byte = head_desc.data_second;
            default:        sel_byte = 8'h00;
        endcase
        if (head_desc.err) begin
            sel_byte = 8'h00;
        end
    end

    always_comb begin
        active_next  = active_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            if (at_end) begin
                active_next = 1'b0;
            end else begin
                active_next = 1'b1;
                idx_next    = cur_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg  <= sel_byte;
            last_reg  <= at_end && head_desc.ends;
            error_reg <= head_desc.err;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = byte_reg;
    assign m_frame_last = last_reg;
    assign m_error      = error_reg;

    `MTRF_ASSERT(a_active_has_job, !active_reg || head_valid, "byte walk with no job at the head")
    `MTRF_ASSERT(a_idx_in_frame, idx_reg <= BP_DATA_SECOND, "byte position beyond frame end")
    `MTRF_ASSERT_NEXT(a_error_not_last, load && head_desc.err, m_error && !m_frame_last, "error word marked as frame end")
    `MTRF_ASSERT_NEXT(a_pop_clears_walk, pop, !active_reg, "walk still active after job pop")

endmodule

`default_nettype wire

// File: sv/modbus_tcp_request_framer.sv
// Modbus TCP request framer: request words in, frame bytes out.
//
// Input channel (s_): one word per request start (function code, start address,
// count, first value) followed, for write-multiple requests, by one word per
// further packed coil or register word. Output channel (m_): one frame byte per
// word with m_frame_last on the final byte; an over-limit write-multiple count
// gives a single word with m_error set and no frame.
// An item is queued when accepted, then its first byte is registered onto m_.
// A frame start item gives 12 to 15 bytes, a continuation item 1 or 2 bytes;
// the output runs at one byte per cycle while m_ready is high, through the single
// output byte register, and the next item may be taken while one is going out.
// A two-entry job queue sits between the classifier and the byte serializer, so
// the next item is taken while earlier bytes are still going out.
// When m_ready is low the current byte holds, the queue fills, then s_ready drops.
// Reset (aresetn low at a clock edge) clears the transaction id to zero, drops
// any partly sent frame and any queued jobs, and ends a pending write-multiple.
`default_nettype none

module modbus_tcp_request_framer import mtrf_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_func,
    input  wire logic [15:0]  s_start_addr,
    input  wire logic [15:0]  s_count,
    input  wire logic [15:0]  s_value,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [7:0]        m_frame_byte,
    output logic              m_frame_last,
    output logic              m_error
);

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_head_valid;
    desc_t q_push_desc;
    desc_t q_head_desc;

    mtrf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_start_addr (s_start_addr),
        .s_count      (s_count),
        .s_value      (s_value),
        .q_push       (q_push),
        .q_desc       (q_push_desc),
        .q_full       (q_full)
    );

    mtrf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_push_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_desc  (q_head_desc)
    );

    mtrf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (q_head_valid),
        .head_desc    (q_head_desc),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_last (m_frame_last),
        .m_error      (m_error)
    );

endmodule

`default_nettype wire

// File: tb/modbus_tcp_request_checker.sv
// checker for the request framer: predicts frame bytes from accepted words and compares
module modbus_tcp_request_checker import mtrf_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_func,
    input  wire logic [15:0] s_start_addr,
    input  wire logic [15:0] s_count,
    input  wire logic [15:0] s_value,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [7:0]  m_frame_byte,
    input  wire logic        m_frame_last,
    input  wire logic        m_error,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } frame_byte_t;

    frame_byte_t frame_q[$];
    frame_byte_t want_b;

    // predicted framer state
    logic [15:0] next_tid;
    logic [6:0]  words_left;
    logic        coil_words;
    logic        odd_tail;
    int          bytes_seen;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on frame byte %0d: %s got %0h want %0h", bytes_seen, what, got, want);
        fail_count = fail_count + 1;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        frame_q.push_back({b, last, 1'b0});
    endtask

    // coil words go low byte first, register words high byte first
    task automatic push_data_word(input logic [15:0] w, input logic last);
        logic [7:0] first_b;
        logic [7:0] second_b;
        first_b  = coil_words ? w[7:0] : w[15:8];
        second_b = coil_words ? w[15:8] : w[7:0];
        if (last && odd_tail) begin
            push_byte(first_b, 1'b1);
        end else begin
            push_byte(first_b, 1'b0);
            push_byte(second_b, last);
        end
    endtask

    task automatic frame_request(input logic [7:0] f, input logic [15:0] addr,
                                 input logic [15:0] cnt, input logic [15:0] val);
        int          c;
        int          nbytes;
        int          nwords;
        logic [15:0] len;
        logic [15:0] coil_val;
        c      = int'(cnt);
        nbytes = 0;
        nwords = 0;
        len    = 16'(BASE_LEN);
        if (words_left != 0) begin
            push_data_word(val, words_left == 7'd1);
            words_left = words_left - 7'd1;
        end else if ((f == FC_WRITE_COILS && cnt > COIL_LIMIT) ||
                     (f == FC_WRITE_REGS && cnt > REG_LIMIT)) begin
            frame_q.push_back({8'h00, 1'b0, 1'b1});
        end else begin
            if (f == FC_WRITE_COILS) begin
                nbytes = (c + 7) / 8;
                nwords = (nbytes + 1) / 2;
                len    = 16'(MULTI_LEN) + 16'(nbytes);
            end else if (f == FC_WRITE_REGS) begin
                nbytes = c * 2;
                nwords = c;
                len    = 16'(MULTI_LEN) + 16'(nbytes);
            end
            push_byte(next_tid[15:8], 1'b0);
            push_byte(next_tid[7:0], 1'b0);
            push_byte(8'h00, 1'b0);
            push_byte(8'h00, 1'b0);
            push_byte(len[15:8], 1'b0);
            push_byte(len[7:0], 1'b0);
            push_byte(UNIT_ID, 1'b0);
            push_byte(f, 1'b0);
            push_byte(addr[15:8], 1'b0);
            push_byte(addr[7:0], 1'b0);
            if (f == FC_WRITE_COIL) begin
                coil_val = (val != 16'd0) ? COIL_ON : 16'd0;
                push_byte(coil_val[15:8], 1'b0);
                push_byte(coil_val[7:0], 1'b1);
            end else if (f == FC_WRITE_REG) begin
                push_byte(val[15:8], 1'b0);
                push_byte(val[7:0], 1'b1);
            end else if (f == FC_WRITE_COILS || f == FC_WRITE_REGS) begin
                coil_words = (f == FC_WRITE_COILS);
                odd_tail   = coil_words && nbytes[0];
                push_byte(cnt[15:8], 1'b0);
                push_byte(cnt[7:0], 1'b0);
                push_byte(nbytes[7:0], nwords == 0);
                if (nwords != 0) begin
                    push_data_word(val, nwords == 1);
                    words_left = 7'(nwords - 1);
                end
            end else begin
                push_byte(cnt[15:8], 1'b0);
                push_byte(cnt[7:0], 1'b1);
            end
            next_tid = next_tid + 16'd1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_q.delete();
            next_tid   = 16'd0;
            words_left = 7'd0;
            coil_words = 1'b0;
            odd_tail   = 1'b0;
            bytes_seen = 0;
            fail_count = 0;
            pending    <= 0;
        end else begin
            if (s_valid && s_ready) begin
                frame_request(s_func, s_start_addr, s_count, s_value);
            end
            if (m_valid && m_ready) begin
                if (frame_q.size() == 0) begin
                    report_mismatch("byte with nothing outstanding", int'(m_frame_byte), 0);
                end else begin
                    want_b = frame_q.pop_front();
                    if (m_frame_byte !== want_b.data)
                        report_mismatch("frame_byte", int'(m_frame_byte), int'(want_b.data));
                    if (m_frame_last !== want_b.last)
                        report_mismatch("frame_last", int'(m_frame_last), int'(want_b.last));
                    if (m_error !== want_b.err)
                        report_mismatch("error", int'(m_error), int'(want_b.err));
                end
                bytes_seen = bytes_seen + 1;
            end
            pending <= frame_q.size();
        end
    end

endmodule

// File: tb/tb_modbus_tcp_request_framer.sv
// testbench top for the request framer: stimulus, idling and verdict
module tb_modbus_tcp_request_framer;
    import mtrf_pkg::*;

    localparam logic [7:0] FC_READ_COILS   = 8'h01;
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam int         RANDOM_ITEMS    = 480;
    localparam int         NUM_PHASES      = 4;
    localparam int         CYCLE_LIMIT     = 600000;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_func       = 8'd0;
    logic [15:0] s_start_addr = 16'd0;
    logic [15:0] s_count      = 16'd0;
    logic [15:0] s_value      = 16'd0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_frame_byte;
    logic        m_frame_last;
    logic        m_error;

    int fail_count;
    int pending;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int items_sent = 0;
    int cycles     = 0;

    modbus_tcp_request_framer u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_start_addr (s_start_addr),
        .s_count      (s_count),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_last (m_frame_last),
        .m_error      (m_error)
    );

    modbus_tcp_request_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_start_addr (s_start_addr),
        .s_count      (s_count),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_last (m_frame_last),
        .m_error      (m_error),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[modbus_tcp_request_framer] ERROR");
            $finish;
        end
    end

    // packed data words of a request, the first carried in its first word
    function automatic int data_words(input logic [7:0] f, input logic [15:0] c);
        int n;
        n = int'(c);
        if (f == FC_WRITE_COILS && c <= COIL_LIMIT)
            return ((n + 7) / 8 + 1) / 2;
        else if (f == FC_WRITE_REGS && c <= REG_LIMIT)
            return n;
        else
            return 0;
    endfunction

    task automatic send_word(input logic [7:0] f, input logic [15:0] a,
                             input logic [15:0] c, input logic [15:0] v);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_start_addr <= a;
        s_count      <= c;
        s_value      <= v;
        do @(posedge aclk); while (!s_ready);
        items_sent = items_sent + 1;
    endtask

    // first word plus its continuation words; cut drops some of the tail
    task automatic send_request(input logic [7:0] f, input logic [15:0] a,
                                input logic [15:0] c, input logic [15:0] v, input bit cut);
        int nw;
        int ncont;
        nw = data_words(f, c);
        send_word(f, a, c, v);
        if (nw > 1) begin
            ncont = nw - 1;
            if (cut)
                ncont = int'($urandom_range(ncont - 1));
            repeat (ncont)
                send_word(8'($urandom_range(255)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535)), 16'($urandom_range(65535)));
        end
    endtask

    task automatic random_request();
        logic [7:0]  f;
        logic [15:0] c;
        logic [15:0] v;
        int          sel;
        sel = int'($urandom_range(99));
        if (sel < 15)
            f = FC_WRITE_COIL;
        else if (sel < 30)
            f = FC_WRITE_REG;
        else if (sel < 55)
            f = FC_WRITE_COILS;
        else if (sel < 80)
            f = FC_WRITE_REGS;
        else
            f = 8'($urandom_range(255));
        sel = int'($urandom_range(99));
        if (f == FC_WRITE_COILS) begin
            if (sel < 6)
                c = 16'($urandom_range(65535, COIL_LIMIT + 1));
            else if (sel < 8)
                c = COIL_LIMIT;
            else if (sel < 11)
                c = 16'($urandom_range(COIL_LIMIT));
            else
                c = 16'($urandom_range(40));
        end else if (f == FC_WRITE_REGS) begin
            if (sel < 6)
                c = 16'($urandom_range(65535, REG_LIMIT + 1));
            else if (sel < 8)
                c = REG_LIMIT;
            else if (sel < 11)
                c = 16'($urandom_range(REG_LIMIT));
            else
                c = 16'($urandom_range(8));
        end else begin
            c = 16'($urandom_range(65535));
        end
        v = ($urandom_range(99) < 25) ? 16'd0 : 16'($urandom_range(65535));
        send_request(f, 16'($urandom_range(65535)), c, v, $urandom_range(99) < 4);
    endtask

    // let every outstanding frame byte drain before going on
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int base;
        int phase;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_pct  = 21;
        stall_pct = 21;
        send_request(FC_WRITE_COIL, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_request(FC_WRITE_COIL, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b0);
        send_request(FC_WRITE_COIL, 16'h0100, 16'h0000, 16'h8000, 1'b0);
        send_request(FC_WRITE_REG, 16'h1234, 16'h0000, 16'hFFFF, 1'b0);
        send_request(FC_WRITE_REG, 16'h0001, 16'h0000, 16'h0000, 1'b0);
        send_request(FC_READ_HOLDING, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        send_request(FC_READ_COILS, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        send_request('1, 16'hA5A5, 16'h5A5A, 16'h1111, 1'b0);
        send_request('0, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        // zero count write-multiple ends on the byte count
        send_request(FC_WRITE_COILS, 16'h0010, 16'h0000, 16'hFFFF, 1'b0);
        send_request(FC_WRITE_REGS, 16'h0020, 16'h0000, 16'hFFFF, 1'b0);
        // over the limit: error word, no frame
        send_request(FC_WRITE_COILS, 16'h0030, COIL_LIMIT + 16'd1, 16'h1234, 1'b0);
        send_request(FC_WRITE_REGS, 16'h0040, REG_LIMIT + 16'd1, 16'h1234, 1'b0);
        send_request(FC_WRITE_REGS, 16'h0050, 16'hFFFF, 16'h1234, 1'b0);
        // coil byte counts odd and even: on an odd count the last word gives its low byte only
        send_request(FC_WRITE_COILS, 16'h0060, 16'd8, 16'hBEEF, 1'b0);
        send_request(FC_WRITE_COILS, 16'h0070, 16'd17, 16'hC0DE, 1'b0);
        send_request(FC_WRITE_COILS, 16'h0080, 16'd32, 16'h0F0F, 1'b0);
        send_request(FC_WRITE_REGS, 16'h0090, 16'd3, 16'h8001, 1'b0);
        wait_drained();

        base = items_sent;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 79;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 79;
                end
                default: begin
                    idle_pct  = 21;
                    stall_pct = 21;
                end
            endcase
            while (items_sent - base < RANDOM_ITEMS * (phase + 1) / NUM_PHASES)
                random_request();
            wait_drained();
        end

        stall_pct = 0;
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("[modbus_tcp_request_framer] OK");
        else
            $display("[modbus_tcp_request_framer] ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/mtrf_pkg.sv
sv/mtrf_queue.sv
sv/mtrf_front.sv
sv/mtrf_back.sv
sv/modbus_tcp_request_framer.sv
tb/modbus_tcp_request_checker.sv
tb/tb_modbus_tcp_request_framer.sv
